// ----- rtl/crae_pkg.sv -----
`timescale 1ns / 1ps
package crae_pkg;

  localparam int IDX_W = 12;
  localparam int VAL_W = 32;
  localparam int SUM_W = 40;
  localparam int ROW_W = 12;

  localparam int STORE_DEPTH_DEF = 4096;
  localparam int MAX_ROW_LEN_DEF = 256;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_NONZERO = 2'd1,
    OP_EMPTY   = 2'd2,
    OP_RESTART = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t                   opcode;
    logic [IDX_W-1:0]          index;
    logic signed [VAL_W-1:0]   value;
    logic                      row_last;
  } item_t;

  typedef struct packed {
    logic [ROW_W-1:0]          row_number;
    logic signed [VAL_W-1:0]   row_mean;
  } result_t;

  typedef struct packed {
    logic capture;
    logic red_stage1;
    logic red_out;
    logic red_stage2;
    logic wr_load;
    logic rd;
    logic acc;
    logic div_start;
    logic mean_load;
    logic finish;
  } cmd_t;

  typedef struct packed {
    opcode_t opcode;
    logic    row_last;
    logic    div_busy;
    logic    out_free;
  } status_t;

endpackage

// ----- rtl/crae_div.sv -----
`timescale 1ns / 1ps
module crae_div import crae_pkg::*; #(
  parameter int CW = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CW-1:0]    divisor,
  output logic             busy,
  output logic [SUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [CW-1:0]    rem;
  logic [CW-1:0]    dsr;
  logic [SUM_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic [CW:0]      trial;
  logic             ge;

  // one quotient bit a cycle, restoring
  assign trial = {rem, quo[SUM_W-1]};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(SUM_W);
      quo  <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (busy) begin
      rem <= ge ? CW'(trial - {1'b0, dsr}) : CW'(trial);
      quo <= {quo[SUM_W-2:0], ge};
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quotient = quo;

  a_busy_divisor: assert property (@(posedge clk) disable iff (rst)
    busy |-> dsr != '0)
    else $error("divider running with zero divisor");

endmodule

// ----- rtl/crae_datapath.sv -----
`timescale 1ns / 1ps
module crae_datapath import crae_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int MAX_ROW_LEN = MAX_ROW_LEN_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  item_t            item,
  input  logic             cfg_write,
  input  logic [IDX_W-1:0] cfg_data,
  input  cmd_t             cmd,
  output status_t          status,
  output logic             result_valid,
  input  logic             result_stall,
  output result_t          result
);

  localparam int AW        = $clog2(STORE_DEPTH);
  localparam int CW        = $clog2(MAX_ROW_LEN + 1);
  localparam int OPW       = IDX_W + 1;
  localparam int RW        = ((AW > OPW) ? AW : OPW) + 1;
  localparam int RED_SHIFT = 24;
  localparam int RED_MUL   = (1 << RED_SHIFT) / STORE_DEPTH;
  localparam int MW        = $clog2(RED_MUL + 1);

  localparam logic [MW-1:0]    RED_MUL_V = MW'(RED_MUL);
  localparam logic [RW-1:0]    DEPTH_R   = RW'(STORE_DEPTH);
  localparam logic [CW-1:0]    MAX_CNT   = CW'(MAX_ROW_LEN);
  localparam logic [SUM_W-1:0] POS_LIM   = SUM_W'(64'h7FFF_FFFF);
  localparam logic [SUM_W-1:0] NEG_LIM   = SUM_W'(64'h8000_0000);
  localparam logic [VAL_W-1:0] MEAN_MAX  = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] MEAN_MIN  = 32'h8000_0000;
  localparam logic [SUM_W-1:0] SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};

  logic [IDX_W-1:0]        out_base;
  opcode_t                 opcode;
  logic [IDX_W-1:0]        index;
  logic [VAL_W-1:0]        value;
  logic                    row_last;

  logic signed [SUM_W-1:0] row_sum;
  logic [CW-1:0]           count;
  logic [ROW_W-1:0]        row_counter;

  logic [OPW-1:0]          opnd;
  logic [OPW+MW-1:0]       prod;
  logic [AW-1:0]           addr;
  logic [VAL_W-1:0]        rdata;
  logic [VAL_W-1:0]        mem [STORE_DEPTH];

  logic                    neg;
  logic [VAL_W-1:0]        mean;

  logic [OPW-1:0]          red_sel;
  logic [OPW-1:0]          red_q;
  logic [OPW+RW-1:0]       red_qd;
  logic [RW-1:0]           red_diff;
  logic [RW-1:0]           red_rem;

  logic signed [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0]        sum_sat;
  logic [SUM_W-1:0]        magnitude;
  logic [SUM_W-1:0]        quotient;
  logic                    div_busy;
  logic [VAL_W-1:0]        mean_next;

  // address modulo the store depth: reciprocal estimate, then one correction
  assign red_sel  = cmd.red_out ? (OPW'(out_base) + OPW'(row_counter)) : OPW'(index);
  assign red_q    = OPW'(prod >> RED_SHIFT);
  assign red_qd   = red_q * DEPTH_R;
  assign red_diff = RW'(opnd) - RW'(red_qd);
  assign red_rem  = (red_diff >= DEPTH_R) ? (red_diff - DEPTH_R) : red_diff;

  assign sum_wide = {row_sum[SUM_W-1], row_sum}
                  + {{(SUM_W+1-VAL_W){rdata[VAL_W-1]}}, rdata};
  assign sum_sat  = (sum_wide[SUM_W] != sum_wide[SUM_W-1])
                  ? (sum_wide[SUM_W] ? SUM_MIN : SUM_MAX)
                  : sum_wide[SUM_W-1:0];

  assign magnitude = row_sum[SUM_W-1] ? SUM_W'(-row_sum) : SUM_W'(row_sum);

  always_comb begin
    if (!neg) begin
      mean_next = (quotient > POS_LIM) ? MEAN_MAX : quotient[VAL_W-1:0];
    end else begin
      mean_next = (quotient > NEG_LIM) ? MEAN_MIN : VAL_W'(-quotient[VAL_W-1:0]);
    end
  end

  crae_div #(
    .CW (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (magnitude),
    .divisor  (count),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_base     <= '0;
      row_sum      <= '0;
      count        <= '0;
      row_counter  <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        out_base <= cfg_data;
      end
      if (cmd.capture && item.opcode == OP_RESTART) begin
        row_counter <= '0;
        row_sum     <= '0;
        count       <= '0;
      end
      if (cmd.acc) begin
        row_sum <= sum_sat;
        if (count < MAX_CNT) begin
          count <= count + CW'(1);
        end
      end
      if (cmd.finish) begin
        row_counter  <= row_counter + ROW_W'(1);
        row_sum      <= '0;
        count        <= '0;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      opcode   <= item.opcode;
      index    <= item.index;
      value    <= item.value;
      row_last <= item.row_last;
      if (item.opcode == OP_EMPTY) begin
        mean <= '0;
      end
    end
    if (cmd.red_stage1) begin
      opnd <= red_sel;
      prod <= red_sel * RED_MUL_V;
    end
    if (cmd.red_stage2) begin
      addr <= AW'(red_rem);
    end
    if (cmd.div_start) begin
      neg <= row_sum[SUM_W-1];
    end
    if (cmd.mean_load) begin
      mean <= mean_next;
    end
    if (cmd.finish) begin
      result.row_number <= row_counter;
      result.row_mean   <= mean;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_load || cmd.finish) begin
      mem[addr] <= cmd.finish ? mean : value;
    end
    if (cmd.rd) begin
      rdata <= mem[addr];
    end
  end

  assign status.opcode   = opcode;
  assign status.row_last = row_last;
  assign status.div_busy = div_busy;
  assign status.out_free = !result_valid || !result_stall;

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!result_valid || !result_stall))
    else $error("result overwritten while stalled");

  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.rd || cmd.wr_load || cmd.finish) |-> ({1'b0, addr} < (AW+1)'(STORE_DEPTH)))
    else $error("store address out of range");

  a_finish_row: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> result_valid && result.row_number == $past(row_counter))
    else $error("result row number mismatch");

  a_acc_count: assert property (@(posedge clk) disable iff (rst)
    cmd.acc |=> count != '0)
    else $error("entry count zero after accumulate");

endmodule

// ----- rtl/crae_ctrl.sv -----
`timescale 1ns / 1ps
module crae_ctrl import crae_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  opcode_t item_opcode,
  output logic    item_stall,
  output cmd_t    cmd,
  input  status_t status
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RED1,
    S_RED2,
    S_WRITE,
    S_READ,
    S_ACC,
    S_DSTART,
    S_DIV,
    S_MEAN,
    S_FIN
  } state_t;

  state_t state, state_next;
  logic   tail, tail_next;
  logic   accept;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;

  always_comb begin
    state_next = state;
    tail_next  = tail;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (item_opcode)
            OP_LOAD, OP_NONZERO: begin
              state_next = S_RED1;
              tail_next  = 1'b0;
            end
            OP_EMPTY: begin
              state_next = S_RED1;
              tail_next  = 1'b1;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_RED1: state_next = S_RED2;
      S_RED2: begin
        if (tail) begin
          state_next = S_FIN;
        end else if (status.opcode == OP_LOAD) begin
          state_next = S_WRITE;
        end else begin
          state_next = S_READ;
        end
      end
      S_WRITE: state_next = S_IDLE;
      S_READ:  state_next = S_ACC;
      S_ACC:   state_next = status.row_last ? S_DSTART : S_IDLE;
      S_DSTART: state_next = S_DIV;
      S_DIV: begin
        if (!status.div_busy) begin
          state_next = S_MEAN;
        end
      end
      S_MEAN: begin
        state_next = S_RED1;
        tail_next  = 1'b1;
      end
      S_FIN: begin
        if (status.out_free) begin
          state_next = S_IDLE;
          tail_next  = 1'b0;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.capture = accept;
    case (state)
      S_RED1: begin
        cmd.red_stage1 = 1'b1;
        cmd.red_out    = tail;
      end
      S_RED2:   cmd.red_stage2 = 1'b1;
      S_WRITE:  cmd.wr_load    = 1'b1;
      S_READ:   cmd.rd         = 1'b1;
      S_ACC:    cmd.acc        = 1'b1;
      S_DSTART: cmd.div_start  = 1'b1;
      S_MEAN:   cmd.mean_load  = 1'b1;
      S_FIN:    cmd.finish     = status.out_free;
      default:  cmd.red_out    = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tail  <= 1'b0;
    end else begin
      state <= state_next;
      tail  <= tail_next;
    end
  end

  a_fin_tail: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN |-> tail)
    else $error("row finish reached without a row-end address");

endmodule

// ----- rtl/csr_row_average_engine.sv -----
`timescale 1ns / 1ps
// Sparse row-averaging engine.
// Input channel (item_valid / item_stall / item): one item per handshake.
//   Load items write a Q16.16 value into the vector store; nonzero items add
//   the store entry at their column into the row accumulator; an empty-row
//   item closes a row with mean 0; a restart item clears the row numbering.
// Output channel (result_valid / result_stall / result): one item per closed
//   row, carrying the row number and the Q16.16 mean truncated toward zero.
//   Each mean is also written back at out_base plus row number mod depth.
// Configuration channel (cfg_valid / cfg_ready / cfg_data): writes out_base;
//   always ready, write only while the engine is idle.
// Timing: one item is in flight at a time. A load runs address reduction
//   and a store write, a nonzero reduction, store read and accumulate, an
//   empty row reduction and a finish that may wait for the output register.
//   A row-ending nonzero adds the 40-step bit-serial divider and a reduction.
// Stall: a finished result sits in the output register; the next item is
//   still taken, and only a second row end waits for that register to drain.
// Reset: clears out_base, row sum, entry count and row numbering; store
//   contents stay undefined until loaded, and no clearing pass runs.
module csr_row_average_engine import crae_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int MAX_ROW_LEN = MAX_ROW_LEN_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  item_t            item,
  output logic             result_valid,
  input  logic             result_stall,
  output result_t          result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  // the user must write configuration only while idle; the block leaves this to the user, so always take it
  assign cfg_ready = 1'b1;

  crae_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_opcode (item.opcode),
    .item_stall  (item_stall),
    .cmd         (cmd),
    .status      (status)
  );

  crae_datapath #(
    .STORE_DEPTH (STORE_DEPTH),
    .MAX_ROW_LEN (MAX_ROW_LEN)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
